[rtl/iphp_pkg.sv]
// Shared types, protocol codes and helpers for the IP header parser.
package iphp_pkg;

  // Result status codes
  localparam logic [1:0] ST_V4  = 2'd0;
  localparam logic [1:0] ST_V6  = 2'd1;
  localparam logic [1:0] ST_BAD = 2'd2;

  // IP version codes
  localparam logic [3:0] VER_4 = 4'd4;
  localparam logic [3:0] VER_6 = 4'd6;

  // Protocol and extension header numbers
  localparam logic [7:0] PROTO_HOPOPT  = 8'd0;
  localparam logic [7:0] PROTO_TCP     = 8'd6;
  localparam logic [7:0] PROTO_UDP     = 8'd17;
  localparam logic [7:0] PROTO_ROUTING = 8'd43;
  localparam logic [7:0] PROTO_FRAG    = 8'd44;
  localparam logic [7:0] PROTO_AH      = 8'd51;
  localparam logic [7:0] PROTO_DSTOPTS = 8'd60;

  // TCP flag masks
  localparam logic [7:0] TCP_SYN = 8'h02;
  localparam logic [7:0] TCP_ACK = 8'h10;

  // Header sizes in bytes
  localparam logic [15:0] IPV4_MIN_HDR = 16'd20;
  localparam logic [15:0] IPV6_HDR     = 16'd40;
  localparam logic [15:0] FRAG_HDR     = 16'd8;
  localparam logic [16:0] L4_PORT_SPAN = 17'd4;
  localparam logic [16:0] TCP_MIN_SPAN = 17'd14;
  localparam logic [15:0] TCP_FLAG_OFS = 16'd13;

  // Fixed byte positions in the IP headers
  localparam logic [15:0] V4_PROTO_POS   = 16'd9;
  localparam logic [15:0] V4_SRC_FIRST   = 16'd12;
  localparam logic [15:0] V4_SRC_LAST    = 16'd15;
  localparam logic [15:0] V4_DST_FIRST   = 16'd16;
  localparam logic [15:0] V4_DST_LAST    = 16'd19;
  localparam logic [15:0] V6_NEXT_POS    = 16'd6;
  localparam logic [15:0] V6_SRC_HI_FIRST = 16'd8;
  localparam logic [15:0] V6_SRC_HI_LAST  = 16'd15;
  localparam logic [15:0] V6_SRC_LO_FIRST = 16'd16;
  localparam logic [15:0] V6_SRC_LO_LAST  = 16'd23;
  localparam logic [15:0] V6_DST_HI_FIRST = 16'd24;
  localparam logic [15:0] V6_DST_HI_LAST  = 16'd31;
  localparam logic [15:0] V6_DST_LO_FIRST = 16'd32;
  localparam logic [15:0] V6_DST_LO_LAST  = 16'd39;

  // Parse phase codes
  localparam logic PH_IDLE = 1'b0;
  localparam logic PH_BODY = 1'b1;

  // Parameter defaults
  localparam int DEFAULT_MAX_PACKET_LEN  = 65535;
  localparam int DEFAULT_MAX_EXT_HEADERS = 6;

  // Per-packet parse state, also the snapshot handed to the result stage
  typedef struct packed {
    logic [15:0] byte_count;
    logic [3:0]  ip_ver;
    logic [15:0] l4_offset;
    logic [7:0]  next_proto;
    logic [15:0] ext_start;
    logic [2:0]  ext_count;
    logic [63:0] src_hi;
    logic [63:0] src_lo;
    logic [63:0] dst_hi;
    logic [63:0] dst_lo;
    logic [15:0] l4_sport;
    logic [15:0] l4_dport;
    logic [7:0]  flag_byte;
    logic        direction;
    logic        error_seen;
  } pkt_state_t;

  // One parsed result
  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] source_addr_high;
    logic [63:0] source_addr_low;
    logic [63:0] dest_addr_high;
    logic [63:0] dest_addr_low;
    logic [7:0]  protocol;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [7:0]  tcp_flag_bits;
    logic        new_connection;
    logic [15:0] packet_length;
    logic        direction_out;
  } result_t;

  function automatic logic is_ext_hdr(input logic [7:0] proto);
    is_ext_hdr = (proto == PROTO_HOPOPT) || (proto == PROTO_ROUTING) ||
                 (proto == PROTO_DSTOPTS) || (proto == PROTO_FRAG) ||
                 (proto == PROTO_AH);
  endfunction

  function automatic logic is_l4(input logic [7:0] proto);
    is_l4 = (proto == PROTO_TCP) || (proto == PROTO_UDP);
  endfunction

endpackage

[rtl/iphp_parse.sv]
// Byte-wise parse state: counters, offsets, extension walk and field capture.
module iphp_parse #(
  parameter int MAX_PACKET_LEN  = iphp_pkg::DEFAULT_MAX_PACKET_LEN,
  parameter int MAX_EXT_HEADERS = iphp_pkg::DEFAULT_MAX_EXT_HEADERS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  fire,
  input  logic [7:0]            data_byte,
  input  logic                  last_byte,
  input  logic                  direction,
  output iphp_pkg::pkt_state_t  pkt_next
);

  iphp_pkg::pkt_state_t pkt;
  logic                 phase;
  logic [7:0]           pending;
  logic [7:0]           pending_next;

  iphp_pkg::pkt_state_t cur;
  logic [7:0]           cur_pend;
  logic [15:0]          idx;
  logic                 walk;
  logic [8:0]           hop_units;
  logic [8:0]           ah_units;
  logic [11:0]          ext_len;
  logic [15:0]          grown_start;

  always_comb begin
    cur      = pkt;
    cur_pend = pending;
    if (phase == iphp_pkg::PH_IDLE) begin
      cur           = '0;
      cur.direction = direction;
      cur_pend      = '0;
    end
    pkt_next     = cur;
    pending_next = cur_pend;
    idx          = cur.byte_count;
    walk = (cur.ip_ver == iphp_pkg::VER_6) &&
           (cur.ext_count < 3'(MAX_EXT_HEADERS)) &&
           iphp_pkg::is_ext_hdr(cur.next_proto);
    hop_units = {1'b0, data_byte} + 9'd1;
    ah_units  = {1'b0, data_byte} + 9'd2;
    ext_len   = (cur.next_proto == iphp_pkg::PROTO_AH) ? {1'b0, ah_units, 2'b00}
                                                       : {hop_units, 3'b000};
    grown_start = cur.ext_start + {4'b0000, ext_len};

    if (idx == 16'd0) begin
      pkt_next.ip_ver     = data_byte[7:4];
      pkt_next.l4_offset  = (data_byte[7:4] == iphp_pkg::VER_4) ?
                            {10'd0, data_byte[3:0], 2'b00} : iphp_pkg::IPV6_HDR;
      pkt_next.ext_start  = pkt_next.l4_offset;
    end else if (cur.ip_ver == iphp_pkg::VER_4) begin
      if (idx == iphp_pkg::V4_PROTO_POS) begin
        pkt_next.next_proto = data_byte;
      end else if (idx >= iphp_pkg::V4_SRC_FIRST && idx <= iphp_pkg::V4_SRC_LAST) begin
        pkt_next.src_lo = {32'd0, cur.src_lo[23:0], data_byte};
      end else if (idx >= iphp_pkg::V4_DST_FIRST && idx <= iphp_pkg::V4_DST_LAST) begin
        pkt_next.dst_lo = {32'd0, cur.dst_lo[23:0], data_byte};
      end else if (iphp_pkg::is_l4(cur.next_proto)) begin
        if (idx == cur.l4_offset) pkt_next.l4_sport[15:8] = data_byte;
        else if (idx == cur.l4_offset + 16'd1) pkt_next.l4_sport[7:0] = data_byte;
        else if (idx == cur.l4_offset + 16'd2) pkt_next.l4_dport[15:8] = data_byte;
        else if (idx == cur.l4_offset + 16'd3) pkt_next.l4_dport[7:0] = data_byte;
        else if (cur.next_proto == iphp_pkg::PROTO_TCP &&
                 idx == cur.l4_offset + iphp_pkg::TCP_FLAG_OFS) begin
          pkt_next.flag_byte = data_byte;
        end
      end
    end else if (cur.ip_ver == iphp_pkg::VER_6) begin
      if (idx == iphp_pkg::V6_NEXT_POS) begin
        pkt_next.next_proto = data_byte;
      end else if (idx >= iphp_pkg::V6_SRC_HI_FIRST && idx <= iphp_pkg::V6_SRC_HI_LAST) begin
        pkt_next.src_hi = {cur.src_hi[55:0], data_byte};
      end else if (idx >= iphp_pkg::V6_SRC_LO_FIRST && idx <= iphp_pkg::V6_SRC_LO_LAST) begin
        pkt_next.src_lo = {cur.src_lo[55:0], data_byte};
      end else if (idx >= iphp_pkg::V6_DST_HI_FIRST && idx <= iphp_pkg::V6_DST_HI_LAST) begin
        pkt_next.dst_hi = {cur.dst_hi[55:0], data_byte};
      end else if (idx >= iphp_pkg::V6_DST_LO_FIRST && idx <= iphp_pkg::V6_DST_LO_LAST) begin
        pkt_next.dst_lo = {cur.dst_lo[55:0], data_byte};
      end else if (walk) begin
        if (idx == cur.ext_start) begin
          pending_next = data_byte;
          // fragment header has a fixed length, advance on its first byte
          if (cur.next_proto == iphp_pkg::PROTO_FRAG) begin
            pkt_next.next_proto = data_byte;
            pkt_next.ext_start  = cur.ext_start + iphp_pkg::FRAG_HDR;
            pkt_next.ext_count  = cur.ext_count + 3'd1;
            pkt_next.l4_offset  = cur.ext_start + iphp_pkg::FRAG_HDR;
          end
        end else if (idx == cur.ext_start + 16'd1) begin
          pkt_next.next_proto = cur_pend;
          pkt_next.ext_start  = grown_start;
          pkt_next.ext_count  = cur.ext_count + 3'd1;
          pkt_next.l4_offset  = grown_start;
        end
      end else if (iphp_pkg::is_l4(cur.next_proto)) begin
        if (idx == cur.l4_offset) pkt_next.l4_sport[15:8] = data_byte;
        else if (idx == cur.l4_offset + 16'd1) pkt_next.l4_sport[7:0] = data_byte;
        else if (idx == cur.l4_offset + 16'd2) pkt_next.l4_dport[15:8] = data_byte;
        else if (idx == cur.l4_offset + 16'd3) pkt_next.l4_dport[7:0] = data_byte;
        else if (cur.next_proto == iphp_pkg::PROTO_TCP &&
                 idx == cur.l4_offset + iphp_pkg::TCP_FLAG_OFS) begin
          pkt_next.flag_byte = data_byte;
        end
      end
    end

    // saturate the count; an extra byte marks the packet bad
    if (idx < 16'(MAX_PACKET_LEN)) begin
      pkt_next.byte_count = idx + 16'd1;
    end else begin
      pkt_next.error_seen = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= iphp_pkg::PH_IDLE;
    end else if (fire) begin
      phase <= last_byte ? iphp_pkg::PH_IDLE : iphp_pkg::PH_BODY;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      pkt     <= pkt_next;
      pending <= pending_next;
    end
  end

endmodule

[rtl/iphp_result.sv]
// Snapshot of a finished packet, final length and header checks and the result register.
module iphp_result #(
  parameter int MAX_EXT_HEADERS = iphp_pkg::DEFAULT_MAX_EXT_HEADERS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  iphp_pkg::pkt_state_t  pkt_next,
  output logic                  snap_ready,
  output logic                  result_valid,
  input  logic                  result_ready,
  output iphp_pkg::result_t     result
);

  iphp_pkg::pkt_state_t snap;
  logic                 snap_valid;
  logic                 snap_move;
  iphp_pkg::result_t    result_next;

  logic [16:0] len_w;
  logic [16:0] l4_w;
  logic        walk;
  logic        l4_proto;
  logic        ok;
  logic [1:0]  st;

  assign snap_move  = snap_valid && (!result_valid || result_ready);
  assign snap_ready = !snap_valid || snap_move;

  always_comb begin
    len_w    = {1'b0, snap.byte_count};
    l4_w     = {1'b0, snap.l4_offset};
    l4_proto = iphp_pkg::is_l4(snap.next_proto);
    walk = (snap.ip_ver == iphp_pkg::VER_6) &&
           (snap.ext_count < 3'(MAX_EXT_HEADERS)) &&
           iphp_pkg::is_ext_hdr(snap.next_proto);
    ok = !snap.error_seen;
    st = iphp_pkg::ST_BAD;
    if (snap.ip_ver == iphp_pkg::VER_4) begin
      ok = ok && (snap.byte_count >= iphp_pkg::IPV4_MIN_HDR) &&
           (snap.l4_offset >= iphp_pkg::IPV4_MIN_HDR) &&
           (snap.l4_offset <= snap.byte_count);
      st = iphp_pkg::ST_V4;
    end else if (snap.ip_ver == iphp_pkg::VER_6) begin
      ok = ok && (snap.byte_count >= iphp_pkg::IPV6_HDR) &&
           (snap.byte_count >= snap.ext_start) && !walk;
      st = iphp_pkg::ST_V6;
    end else begin
      ok = 1'b0;
    end
    if (l4_proto) ok = ok && (len_w >= l4_w + iphp_pkg::L4_PORT_SPAN);
    if (snap.next_proto == iphp_pkg::PROTO_TCP) begin
      ok = ok && (len_w >= l4_w + iphp_pkg::TCP_MIN_SPAN);
    end

    result_next               = '0;
    result_next.status        = ok ? st : iphp_pkg::ST_BAD;
    result_next.packet_length = snap.byte_count;
    result_next.direction_out = snap.direction;
    if (ok) begin
      result_next.source_addr_high = snap.src_hi;
      result_next.source_addr_low  = snap.src_lo;
      result_next.dest_addr_high   = snap.dst_hi;
      result_next.dest_addr_low    = snap.dst_lo;
      result_next.protocol         = snap.next_proto;
      if (l4_proto) begin
        result_next.source_port = snap.l4_sport;
        result_next.dest_port   = snap.l4_dport;
      end
      if (snap.next_proto == iphp_pkg::PROTO_TCP) begin
        result_next.tcp_flag_bits  = snap.flag_byte;
        result_next.new_connection = ((snap.flag_byte & iphp_pkg::TCP_SYN) != 8'd0) &&
                                     ((snap.flag_byte & iphp_pkg::TCP_ACK) == 8'd0);
      end else if (snap.next_proto == iphp_pkg::PROTO_UDP) begin
        result_next.new_connection = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (load) snap_valid <= 1'b1;
      else if (snap_move) snap_valid <= 1'b0;
      if (snap_move) result_valid <= 1'b1;
      else if (result_ready) result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) snap <= pkt_next;
    if (snap_move) result <= result_next;
  end

endmodule

[rtl/ip_packet_header_parser_unit.sv]
// IPv4/IPv6 five-tuple header parser, top level.
// Each finished packet is held in the snapshot register, then in the result register.
// Throughput: one byte per cycle while data_ready is high; one result per packet.
// Per-byte work is set by the parse state update; final checks sit in the result stage.
// The input stalls only when a finished packet waits in the snapshot and the result is held.
// Reset (rst, synchronous) empties both stages and arms the parser for a first byte.
module ip_packet_header_parser_unit #(
  parameter int MAX_PACKET_LEN  = iphp_pkg::DEFAULT_MAX_PACKET_LEN,
  parameter int MAX_EXT_HEADERS = iphp_pkg::DEFAULT_MAX_EXT_HEADERS
) (
  input  logic        clk,
  input  logic        rst,
  // byte stream
  input  logic        data_valid,
  output logic        data_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic        direction,
  // parsed result
  output logic        result_valid,
  input  logic        result_ready,
  output logic [1:0]  status,
  output logic [63:0] source_addr_high,
  output logic [63:0] source_addr_low,
  output logic [63:0] dest_addr_high,
  output logic [63:0] dest_addr_low,
  output logic [7:0]  protocol,
  output logic [15:0] source_port,
  output logic [15:0] dest_port,
  output logic [7:0]  tcp_flag_bits,
  output logic        new_connection,
  output logic [15:0] packet_length,
  output logic        direction_out
);

  iphp_pkg::pkt_state_t pkt_next;
  iphp_pkg::result_t    result;
  logic                 fire;
  logic                 snap_ready;

  // Accept bytes whenever the snapshot stage can take a finished packet;
  // a byte that is not last never needs that slot, but ready stays
  // independent of the payload.
  assign data_ready = snap_ready;
  assign fire       = data_valid && data_ready;

  // Parse state advances once per accepted transaction.
  iphp_parse #(
    .MAX_PACKET_LEN  (MAX_PACKET_LEN),
    .MAX_EXT_HEADERS (MAX_EXT_HEADERS)
  ) u_parse (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .direction (direction),
    .pkt_next  (pkt_next)
  );

  // On the last byte, capture the updated state and settle the checks.
  iphp_result #(
    .MAX_EXT_HEADERS (MAX_EXT_HEADERS)
  ) u_result (
    .clk          (clk),
    .rst          (rst),
    .load         (fire && last_byte),
    .pkt_next     (pkt_next),
    .snap_ready   (snap_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  // Unpack the result register onto the field ports.
  assign status           = result.status;
  assign source_addr_high = result.source_addr_high;
  assign source_addr_low  = result.source_addr_low;
  assign dest_addr_high   = result.dest_addr_high;
  assign dest_addr_low    = result.dest_addr_low;
  assign protocol         = result.protocol;
  assign source_port      = result.source_port;
  assign dest_port        = result.dest_port;
  assign tcp_flag_bits    = result.tcp_flag_bits;
  assign new_connection   = result.new_connection;
  assign packet_length    = result.packet_length;
  assign direction_out    = result.direction_out;

endmodule

[rtl/iphp_checker.sv]
// Port-level assertions for the header parser, bound to the top level.
module iphp_checker (
  input logic        clk,
  input logic        rst,
  input logic        result_valid,
  input logic        result_ready,
  input logic [1:0]  status,
  input logic [63:0] source_addr_high,
  input logic [63:0] source_addr_low,
  input logic [63:0] dest_addr_high,
  input logic [63:0] dest_addr_low,
  input logic [7:0]  protocol,
  input logic [15:0] source_port,
  input logic [15:0] dest_port,
  input logic [7:0]  tcp_flag_bits,
  input logic        new_connection,
  input logic [15:0] packet_length
);

  // a stalled result stays valid with its status, length and protocol held
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      result_valid && $stable(status) && $stable(packet_length) && $stable(protocol))
    else $error("stalled result changed");

  // drop all tuple fields on a bad packet
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && status == iphp_pkg::ST_BAD |->
      source_addr_high == 64'd0 && source_addr_low == 64'd0 &&
      dest_addr_high == 64'd0 && dest_addr_low == 64'd0 && protocol == 8'd0 &&
      source_port == 16'd0 && dest_port == 16'd0 && tcp_flag_bits == 8'd0 &&
      !new_connection)
    else $error("invalid packet carries tuple fields");

  a_v4_high: assert property (@(posedge clk) disable iff (rst)
    result_valid && status == iphp_pkg::ST_V4 |->
      source_addr_high == 64'd0 && dest_addr_high == 64'd0 &&
      source_addr_low[63:32] == 32'd0 && dest_addr_low[63:32] == 32'd0)
    else $error("IPv4 address outside its low 32 bits");

  a_ports_l4: assert property (@(posedge clk) disable iff (rst)
    result_valid && protocol != iphp_pkg::PROTO_TCP && protocol != iphp_pkg::PROTO_UDP |->
      source_port == 16'd0 && dest_port == 16'd0 && !new_connection)
    else $error("ports or new connection without TCP or UDP");

  a_flags_tcp: assert property (@(posedge clk) disable iff (rst)
    result_valid && protocol != iphp_pkg::PROTO_TCP |-> tcp_flag_bits == 8'd0)
    else $error("TCP flags on a non-TCP result");

endmodule

bind ip_packet_header_parser_unit iphp_checker u_iphp_checker (
  .clk              (clk),
  .rst              (rst),
  .result_valid     (result_valid),
  .result_ready     (result_ready),
  .status           (status),
  .source_addr_high (source_addr_high),
  .source_addr_low  (source_addr_low),
  .dest_addr_high   (dest_addr_high),
  .dest_addr_low    (dest_addr_low),
  .protocol         (protocol),
  .source_port      (source_port),
  .dest_port        (dest_port),
  .tcp_flag_bits    (tcp_flag_bits),
  .new_connection   (new_connection),
  .packet_length    (packet_length)
);

[bench/ip_packet_header_parser_unit_test.sv]
`timescale 1ns / 1ps
// Self-checking bench for the IPv4/IPv6 five-tuple header parser.
module ip_packet_header_parser_unit_test;
  import iphp_pkg::*;

  localparam int MAX_LEN      = DEFAULT_MAX_PACKET_LEN;
  localparam int MAX_EXT_HDRS = DEFAULT_MAX_EXT_HEADERS;
  localparam int LONG_HOLD    = 300;   // cycles the result side is held off under pressure
  localparam int TAIL_CYCLES  = 8;     // margin for stray results after the last drain

  typedef logic [7:0] octet_q_t [$];

  // One directed packet: how to build it and, for error cases, the status to expect.
  typedef struct packed {
    logic [3:0]  ver;        // version nibble of the first byte
    logic [3:0]  ihl;        // IPv4 header length in words
    logic [7:0]  proto;      // upper-layer protocol at the end of the chain
    logic [3:0]  ext_n;      // IPv6 extension headers to chain
    logic [7:0]  ext_kind;   // kind of every chained header
    logic [7:0]  ext_len;    // length byte of every chained header
    logic [7:0]  flags;      // TCP flags byte
    logic        rand_fill;  // fill free bytes at random, else with fill
    logic [7:0]  fill;
    logic [16:0] total;      // bytes sent, 0 for the natural length
    logic        dir;
    logic        typed;      // expected result is typed in below, not predicted
    logic [1:0]  want;
  } pkt_row_t;

  localparam int NUM_ROWS = 26;
  localparam pkt_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    // IPv4: SYN only, SYN+ACK over all-ones, UDP at both byte extremes, ICMP with full options
    '{VER_4, 5, PROTO_TCP, 0, 0, 0, TCP_SYN, 1, 0, 0, 1, 0, ST_V4},
    '{VER_4, 5, PROTO_TCP, 0, 0, 0, TCP_SYN | TCP_ACK, 0, 8'hFF, 0, 0, 0, ST_V4},
    '{VER_4, 5, PROTO_UDP, 0, 0, 0, 0, 0, 8'h00, 0, 1, 0, ST_V4},
    '{VER_4, 5, PROTO_UDP, 0, 0, 0, 0, 0, 8'hFF, 0, 0, 0, ST_V4},
    '{VER_4, 15, 8'd1, 0, 0, 0, 0, 1, 0, 0, 1, 0, ST_V4},
    // IPv4 errors: header under 20, header past the end, short packet, cut L4 header
    '{VER_4, 4, PROTO_TCP, 0, 0, 0, TCP_SYN, 1, 0, 0, 0, 1, ST_BAD},
    '{VER_4, 15, PROTO_UDP, 0, 0, 0, 0, 1, 0, 40, 1, 1, ST_BAD},
    '{VER_4, 5, PROTO_UDP, 0, 0, 0, 0, 1, 0, 19, 0, 1, ST_BAD},
    '{VER_4, 5, PROTO_TCP, 0, 0, 0, TCP_SYN, 1, 0, 33, 1, 1, ST_BAD},
    '{VER_4, 5, PROTO_UDP, 0, 0, 0, 0, 1, 0, 23, 0, 1, ST_BAD},
    // unknown versions, one of them a single-byte packet
    '{4'h0, 5, PROTO_UDP, 0, 0, 0, 0, 1, 0, 1, 1, 1, ST_BAD},
    '{4'hF, 5, PROTO_TCP, 0, 0, 0, 0, 1, 0, 30, 0, 1, ST_BAD},
    // IPv6 without extensions
    '{VER_6, 0, PROTO_TCP, 0, 0, 0, 8'hFF, 1, 0, 0, 1, 0, ST_V6},
    '{VER_6, 0, PROTO_UDP, 0, 0, 0, 0, 0, 8'hFF, 0, 0, 0, ST_V6},
    '{VER_6, 0, PROTO_UDP, 0, 0, 0, 0, 1, 0, 39, 1, 1, ST_BAD},
    '{VER_6, 0, 8'd59, 0, 0, 0, 0, 1, 0, 40, 0, 0, ST_V6},
    // IPv6 extension chains: each kind, the longest header, the cap, one over it and a cut chain
    '{VER_6, 0, PROTO_UDP, 1, PROTO_HOPOPT, 0, 0, 1, 0, 0, 1, 0, ST_V6},
    '{VER_6, 0, PROTO_TCP, 1, PROTO_ROUTING, 2, TCP_SYN, 1, 0, 0, 0, 0, ST_V6},
    '{VER_6, 0, PROTO_UDP, 1, PROTO_DSTOPTS, 255, 0, 1, 0, 0, 1, 0, ST_V6},
    '{VER_6, 0, PROTO_TCP, 2, PROTO_FRAG, 0, TCP_ACK, 1, 0, 0, 0, 0, ST_V6},
    '{VER_6, 0, PROTO_UDP, 1, PROTO_AH, 1, 0, 1, 0, 0, 1, 0, ST_V6},
    '{VER_6, 0, PROTO_UDP, 6, PROTO_DSTOPTS, 0, 0, 1, 0, 0, 0, 0, ST_V6},
    '{VER_6, 0, PROTO_TCP, 7, PROTO_ROUTING, 0, TCP_SYN, 1, 0, 0, 1, 0, ST_V6},
    '{VER_6, 0, PROTO_UDP, 2, PROTO_HOPOPT, 1, 0, 1, 0, 50, 0, 1, ST_BAD},
    // longest counted packet, then one byte more
    '{VER_4, 5, PROTO_UDP, 0, 0, 0, 0, 1, 0, 65535, 0, 0, ST_V4},
    '{VER_4, 5, PROTO_UDP, 0, 0, 0, 0, 1, 0, 65536, 1, 1, ST_BAD}
  };

  localparam logic [7:0] EXT_KINDS [5] = '{PROTO_HOPOPT, PROTO_ROUTING, PROTO_DSTOPTS,
                                           PROTO_FRAG, PROTO_AH};

  logic        clk;
  logic        rst          = 1'b1;
  logic        data_valid   = 1'b0;
  logic        data_ready;
  logic [7:0]  data_byte    = 8'h00;
  logic        last_byte    = 1'b0;
  logic        direction    = 1'b0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  logic [1:0]  status;
  logic [63:0] source_addr_high;
  logic [63:0] source_addr_low;
  logic [63:0] dest_addr_high;
  logic [63:0] dest_addr_low;
  logic [7:0]  protocol;
  logic [15:0] source_port;
  logic [15:0] dest_port;
  logic [7:0]  tcp_flag_bits;
  logic        new_connection;
  logic [15:0] packet_length;
  logic        direction_out;

  ip_packet_header_parser_unit dut (
    .clk              (clk),
    .rst              (rst),
    .data_valid       (data_valid),
    .data_ready       (data_ready),
    .data_byte        (data_byte),
    .last_byte        (last_byte),
    .direction        (direction),
    .result_valid     (result_valid),
    .result_ready     (result_ready),
    .status           (status),
    .source_addr_high (source_addr_high),
    .source_addr_low  (source_addr_low),
    .dest_addr_high   (dest_addr_high),
    .dest_addr_low    (dest_addr_low),
    .protocol         (protocol),
    .source_port      (source_port),
    .dest_port        (dest_port),
    .tcp_flag_bits    (tcp_flag_bits),
    .new_connection   (new_connection),
    .packet_length    (packet_length),
    .direction_out    (direction_out)
  );

  // Parsed headers still owed by the block, oldest first.
  result_t headers_due [$];

  int send_idle_pct = 9;
  int recv_idle_pct = 58;
  int hold_asks     = 0;   // bumped by the stimulus to ask for a long result stall
  int holds_done    = 0;   // caught up by the result side once a stall is over
  int mismatches    = 0;
  int results_seen  = 0;
  int packets_sent  = 0;
  int bytes_sent    = 0;

  // Parser shadow state, tracked byte by byte as the block sees it.
  logic        pk_busy = 1'b0;
  logic        pk_dir  = 1'b0;
  int unsigned pk_count, pk_l4, pk_ext_start, pk_ext_n;
  logic [3:0]  pk_ver;
  logic [7:0]  pk_next, pk_pend, pk_flags;
  logic [63:0] pk_src [2];
  logic [63:0] pk_dst [2];
  logic [15:0] pk_port [2];
  logic        pk_err;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

  // True while the IPv6 extension walk still has a header to step over.
  function automatic logic chain_open();
    return pk_ver == VER_6 && pk_ext_n < MAX_EXT_HDRS &&
           (pk_next == PROTO_HOPOPT || pk_next == PROTO_ROUTING ||
            pk_next == PROTO_DSTOPTS || pk_next == PROTO_FRAG || pk_next == PROTO_AH);
  endfunction

  // Capture ports and TCP flags by their offset from the L4 header start.
  task automatic take_l4_byte(input int unsigned pos, input logic [7:0] b);
    if (pk_next == PROTO_TCP || pk_next == PROTO_UDP) begin
      if (pos == pk_l4) pk_port[0][15:8] = b;
      else if (pos == pk_l4 + 1) pk_port[0][7:0] = b;
      else if (pos == pk_l4 + 2) pk_port[1][15:8] = b;
      else if (pos == pk_l4 + 3) pk_port[1][7:0] = b;
      else if (pk_next == PROTO_TCP && pos == pk_l4 + TCP_FLAG_OFS) pk_flags = b;
    end
  endtask

  // Advance the shadow parser by one accepted byte; on the last byte, settle the checks
  // and hand back the header the block must report.
  task automatic parse_header_byte(input logic [7:0] b, input logic fin, input logic dir,
                                   output logic done, output result_t hdr);
    int unsigned pos, span;
    logic        good;
    if (!pk_busy) begin
      pk_count = 0; pk_ver = '0; pk_l4 = 0; pk_next = '0; pk_ext_start = 0;
      pk_ext_n = 0; pk_src = '{64'h0, 64'h0}; pk_dst = '{64'h0, 64'h0};
      pk_port = '{16'h0, 16'h0}; pk_flags = '0; pk_err = 1'b0; pk_pend = '0;
      pk_dir = dir;
      pk_busy = 1'b1;
    end
    pos = pk_count;
    if (pos == 0) begin
      pk_ver = b[7:4];
      pk_l4 = (pk_ver == VER_4) ? int'(b[3:0]) * 4 : int'(IPV6_HDR);
      pk_ext_start = pk_l4;
    end else if (pk_ver == VER_4) begin
      if (pos == V4_PROTO_POS) pk_next = b;
      else if (pos >= V4_SRC_FIRST && pos <= V4_SRC_LAST)
        pk_src[1] = {32'h0, pk_src[1][23:0], b};
      else if (pos >= V4_DST_FIRST && pos <= V4_DST_LAST)
        pk_dst[1] = {32'h0, pk_dst[1][23:0], b};
      else take_l4_byte(pos, b);
    end else if (pk_ver == VER_6) begin
      if (pos == V6_NEXT_POS) pk_next = b;
      else if (pos >= V6_SRC_HI_FIRST && pos <= V6_SRC_HI_LAST) pk_src[0] = {pk_src[0][55:0], b};
      else if (pos >= V6_SRC_LO_FIRST && pos <= V6_SRC_LO_LAST) pk_src[1] = {pk_src[1][55:0], b};
      else if (pos >= V6_DST_HI_FIRST && pos <= V6_DST_HI_LAST) pk_dst[0] = {pk_dst[0][55:0], b};
      else if (pos >= V6_DST_LO_FIRST && pos <= V6_DST_LO_LAST) pk_dst[1] = {pk_dst[1][55:0], b};
      else if (chain_open()) begin
        if (pos == pk_ext_start) begin
          pk_pend = b;
          // fragment headers have a fixed size, so step over them on the first byte
          if (pk_next == PROTO_FRAG) begin
            pk_next = b;
            pk_ext_start += FRAG_HDR;
            pk_ext_n++;
            pk_l4 = pk_ext_start;
          end
        end else if (pos == pk_ext_start + 1) begin
          span = (pk_next == PROTO_AH) ? (int'(b) + 2) * 4 : (int'(b) + 1) * 8;
          pk_next = pk_pend;
          pk_ext_start += span;
          pk_ext_n++;
          pk_l4 = pk_ext_start;
        end
      end else begin
        take_l4_byte(pos, b);
      end
    end
    // the counter saturates; any byte past the cap spoils the packet
    if (pk_count < MAX_LEN) pk_count++;
    else pk_err = 1'b1;

    done = fin;
    hdr = '0;
    if (fin) begin
      good = !pk_err;
      if (pk_ver == VER_4)
        good = good && pk_count >= IPV4_MIN_HDR && pk_l4 >= IPV4_MIN_HDR && pk_l4 <= pk_count;
      else if (pk_ver == VER_6)
        good = good && pk_count >= IPV6_HDR && pk_count >= pk_ext_start && !chain_open();
      else
        good = 1'b0;
      if (good && (pk_next == PROTO_TCP || pk_next == PROTO_UDP))
        good = pk_count >= pk_l4 + L4_PORT_SPAN;
      if (good && pk_next == PROTO_TCP)
        good = pk_count >= pk_l4 + TCP_MIN_SPAN;
      hdr.status = !good ? ST_BAD : (pk_ver == VER_4) ? ST_V4 : ST_V6;
      if (good) begin
        hdr.source_addr_high = pk_src[0];
        hdr.source_addr_low  = pk_src[1];
        hdr.dest_addr_high   = pk_dst[0];
        hdr.dest_addr_low    = pk_dst[1];
        hdr.protocol         = pk_next;
        if (pk_next == PROTO_TCP || pk_next == PROTO_UDP) begin
          hdr.source_port = pk_port[0];
          hdr.dest_port   = pk_port[1];
        end
        if (pk_next == PROTO_TCP) begin
          hdr.tcp_flag_bits  = pk_flags;
          hdr.new_connection = (pk_flags & TCP_SYN) != 0 && (pk_flags & TCP_ACK) == 0;
        end else if (pk_next == PROTO_UDP) begin
          hdr.new_connection = 1'b1;
        end
      end
      hdr.packet_length = pk_count[15:0];
      hdr.direction_out = pk_dir;
      pk_busy = 1'b0;
    end
  endtask

  // Lay out a packet: fixed header, extension chain, L4 header, payload.
  // total > 0 sends exactly that many bytes, 0 the natural length, < 0 a random cut.
  task automatic build_packet(input logic [3:0] ver, input logic [3:0] ihl,
                              input logic [7:0] proto, input octet_q_t kinds,
                              input octet_q_t lens, input logic [7:0] flags, input int fill,
                              input int payload, input int total, output octet_q_t pkt);
    int unsigned spans [$];
    int unsigned l4, full, n, pos, k;
    l4 = (ver == VER_6) ? int'(IPV6_HDR) : int'(ihl) * 4;
    for (k = 0; k < kinds.size(); k++) begin
      if (kinds[k] == PROTO_FRAG) spans.push_back(FRAG_HDR);
      else if (kinds[k] == PROTO_AH) spans.push_back((int'(lens[k]) + 2) * 4);
      else spans.push_back((int'(lens[k]) + 1) * 8);
      l4 += spans[k];
    end
    full = l4 + ((proto == PROTO_TCP) ? 20 : 8) + payload;
    n = (total > 0) ? total : (total < 0) ? $urandom_range(full - 1, 1) : full;
    pkt = {};
    repeat (n) pkt.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
    pkt[0] = {ver, (ver == VER_6) ? pkt[0][3:0] : ihl};
    if (ver == VER_4 && n > V4_PROTO_POS) pkt[V4_PROTO_POS] = proto;
    if (ver == VER_6) begin
      if (n > V6_NEXT_POS) pkt[V6_NEXT_POS] = (kinds.size() != 0) ? kinds[0] : proto;
      pos = IPV6_HDR;
      for (k = 0; k < kinds.size(); k++) begin
        if (pos < n) pkt[pos] = (k + 1 < kinds.size()) ? kinds[k + 1] : proto;
        if (pos + 1 < n) pkt[pos + 1] = lens[k];
        pos += spans[k];
      end
    end
    if (proto == PROTO_TCP && l4 + TCP_FLAG_OFS < n) pkt[l4 + TCP_FLAG_OFS] = flags;
  endtask

  // Offer a packet byte by byte with random gaps, tracking each accepted transaction.
  task automatic send_packet(input octet_q_t pkt, input logic dir, input logic typed,
                             input logic [1:0] typed_status);
    int      i;
    logic    done;
    result_t hdr;
    result_t fixed;
    for (i = 0; i < pkt.size(); i++) begin
      while ($urandom_range(99) < send_idle_pct) begin
        data_valid <= 1'b0;
        @(posedge clk);
      end
      data_valid <= 1'b1;
      data_byte  <= pkt[i];
      last_byte  <= (i == pkt.size() - 1);
      // only the first byte's tag counts; scramble the rest
      direction  <= (i == 0) ? dir : 1'($urandom_range(1));
      @(posedge clk);
      while (!data_ready) @(posedge clk);
      parse_header_byte(pkt[i], i == pkt.size() - 1, dir, done, hdr);
      if (done) begin
        fixed = '0;
        fixed.status = typed_status;
        fixed.packet_length = (pkt.size() > MAX_LEN) ? 16'(MAX_LEN) : 16'(pkt.size());
        fixed.direction_out = dir;
        headers_due.push_back(typed ? fixed : hdr);
      end
    end
    packets_sent++;
    bytes_sent += pkt.size();
  endtask

  // Mostly well-formed IPv4 and IPv6 with random content, some cut short, some noise.
  task automatic send_random_packet();
    octet_q_t    kinds, lens, pkt;
    int unsigned pick, n_ext, k;
    logic [3:0]  ver, ihl;
    logic [7:0]  proto, flags;
    int          total;
    pick = $urandom_range(99);
    ihl = 4'd5;
    n_ext = 0;
    total = 0;
    case ($urandom_range(9))
      0, 1, 2, 3: proto = PROTO_TCP;
      4, 5, 6:    proto = PROTO_UDP;
      default:    proto = 8'($urandom);
    endcase
    case ($urandom_range(7))
      0:       flags = TCP_SYN;
      1:       flags = TCP_SYN | TCP_ACK;
      2:       flags = TCP_ACK;
      3:       flags = 8'h00;
      default: flags = 8'($urandom);
    endcase
    if (pick < 40) begin
      ver = VER_4;
      if ($urandom_range(3) == 0) ihl = 4'($urandom_range(15, 6));
    end else if (pick < 80) begin
      ver = VER_6;
      n_ext = ($urandom_range(9) == 0) ? $urandom_range(7, 5) : $urandom_range(2);
      for (k = 0; k < n_ext; k++) begin
        kinds.push_back(EXT_KINDS[$urandom_range(4)]);
        lens.push_back(8'($urandom_range(3)));
      end
    end else begin
      ver = 4'($urandom_range(15));
      ihl = 4'($urandom_range(15));
      total = $urandom_range(64, 1);
    end
    if (pick < 80 && $urandom_range(9) < 2) total = -1;
    build_packet(ver, ihl, proto, kinds, lens, flags, -1, $urandom_range(12), total, pkt);
    send_packet(pkt, 1'($urandom_range(1)), 1'b0, ST_BAD);
  endtask

  // Stop offering bytes until the block has delivered everything owed.
  task automatic settle_results();
    data_valid <= 1'b0;
    while (headers_due.size() != 0) @(posedge clk);
  endtask

  // Result side: random back-pressure, plus a long stall whenever one is asked for.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_asks != holds_done) begin
        result_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        holds_done = hold_asks;
      end
      result_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // Compare every result transaction against the oldest header owed.
  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && result_valid && result_ready) begin
      if (headers_due.size() == 0) begin
        $error("unexpected result: status %0d, length %0d", status, packet_length);
        mismatches++;
      end else begin
        want = headers_due.pop_front();
        check_field("status", want.status, status);
        check_field("source_addr_high", want.source_addr_high, source_addr_high);
        check_field("source_addr_low", want.source_addr_low, source_addr_low);
        check_field("dest_addr_high", want.dest_addr_high, dest_addr_high);
        check_field("dest_addr_low", want.dest_addr_low, dest_addr_low);
        check_field("protocol", want.protocol, protocol);
        check_field("source_port", want.source_port, source_port);
        check_field("dest_port", want.dest_port, dest_port);
        check_field("tcp_flag_bits", want.tcp_flag_bits, tcp_flag_bits);
        check_field("new_connection", want.new_connection, new_connection);
        check_field("packet_length", want.packet_length, packet_length);
        check_field("direction_out", want.direction_out, direction_out);
        results_seen++;
      end
    end
  end

  // Main sequence: directed packets, then three random phases with different idle mixes.
  initial begin
    octet_q_t kinds, lens, pkt, none;
    pkt_row_t row;
    int       r, phase, i;
    int       start_bytes, start_pkts;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table under the first idle mix.
    for (r = 0; r < NUM_ROWS; r++) begin
      row = DIRECTED_ROWS[r];
      kinds = {};
      lens = {};
      repeat (row.ext_n) begin
        kinds.push_back(row.ext_kind);
        lens.push_back(row.ext_len);
      end
      build_packet(row.ver, row.ihl, row.proto, kinds, lens, row.flags,
                   row.rand_fill ? -1 : int'(row.fill), 0, int'(row.total), pkt);
      send_packet(pkt, row.dir, row.typed, row.want);
    end
    settle_results();

    for (phase = 0; phase < 3; phase++) begin
      // sender dense and receiver busy, then the reverse, then no idling
      send_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 58 : 0;
      recv_idle_pct = (phase == 0) ? 58 : (phase == 1) ? 9 : 0;
      start_bytes = bytes_sent;
      start_pkts  = packets_sent;
      while (bytes_sent - start_bytes < 340 || packets_sent - start_pkts < 20)
        send_random_packet();
      if (phase == 2) begin
        // Hold the result side off and keep pushing short packets so the block backs up.
        hold_asks++;
        for (i = 0; i < 12; i++) begin
          build_packet(VER_4, 4'd5, PROTO_UDP, none, none, 8'h00, -1, 0, 0, pkt);
          send_packet(pkt, 1'($urandom_range(1)), 1'b0, ST_BAD);
        end
      end
      settle_results();
    end

    // Leave room for any stray result to show up.
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Covered %0d packets, %0d bytes: IPv4, IPv6 extension chains, cut, long, malformed",
             packets_sent, bytes_sent);
    $display("Checked %0d headers under three idle mixes, a long result stall and drains",
             results_seen);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
